>>> rtl/core/epwq_pkg.sv
// Shared widths, register indexes, reset values and types for the eye position qualifier.
package epwq_pkg;

   localparam int X_W       = 13;
   localparam int DEPTH_W   = 12;
   localparam int DLIM_W    = 12;
   localparam int PLIM_W    = 13;
   localparam int DX_W      = X_W + 1;
   localparam int DZ_W      = DEPTH_W + 1;
   localparam int MAG_W     = X_W;
   localparam int SQ_W      = 2 * MAG_W + 1;
   localparam int ROOT_BASE = (SQ_W + 1) / 2;

   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 13;

   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_DEPTH  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_LIMIT_PLANAR = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_IDEAL_X      = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_IDEAL_Y      = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_IDEAL_DEPTH  = 3'd4;

   localparam logic [DLIM_W-1:0]         LIMIT_DEPTH_RST  = 12'd50;
   localparam logic [PLIM_W-1:0]         LIMIT_PLANAR_RST = 13'd50;
   localparam logic signed [X_W-1:0]     IDEAL_X_RST      = -13'sd28;
   localparam logic signed [X_W-1:0]     IDEAL_Y_RST      = 13'sd2;
   localparam logic [DEPTH_W-1:0]        IDEAL_DEPTH_RST  = 12'd480;

   typedef struct packed {
      logic evaluated;
      logic too_far;
      logic too_close;
      logic planar_over;
   } win_flags_type;

endpackage

>>> rtl/core/epwq_sqrt.sv
// Bit-serial floor square root, one root bit per cycle.
module epwq_sqrt #(
   parameter int ROOT_W = 18
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [2*ROOT_W-1:0] radicand,
   output logic              done,
   output logic [ROOT_W-1:0] root
);
   import epwq_pkg::*;

   localparam int RAD_W = 2 * ROOT_W;
   localparam int REM_W = ROOT_W + 1;
   localparam int CNT_W = $clog2(ROOT_W + 1);
   localparam logic [CNT_W-1:0] STEPS = CNT_W'(ROOT_W);
   localparam logic [CNT_W-1:0] LAST  = CNT_W'(1);

   logic [RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]  rem_ff;
   logic [ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]  cnt_ff;
   logic              run_ff;
   logic              done_ff;

   logic [REM_W+1:0]  shifted;
   logic [REM_W+2:0]  trial;
   logic              borrow;
   logic [REM_W-1:0]  rem_in;
   logic [ROOT_W-1:0] root_in;

   assign shifted = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial   = {1'b0, shifted} - {2'b00, root_ff, 2'b01};
   assign borrow  = trial[REM_W+2];
   assign rem_in  = borrow ? shifted[REM_W-1:0] : trial[REM_W-1:0];
   assign root_in = {root_ff[ROOT_W-2:0], ~borrow};

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      if (start) begin
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
         cnt_ff  <= STEPS;
         run_ff  <= 1'b1;
      end else if (run_ff) begin
         rad_ff  <= {rad_ff[RAD_W-3:0], 2'b00};
         rem_ff  <= rem_in;
         root_ff <= root_in;
         cnt_ff  <= cnt_ff - LAST;
         if (cnt_ff == LAST) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

>>> rtl/core/epwq_window.sv
// Sliding window of depth offsets and planar distances with running sums and limit checks.
module epwq_window #(
   parameter int WINDOW    = 20,
   parameter int FRAC_BITS = 4
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   input  logic signed [epwq_pkg::DZ_W-1:0]     dz,
   input  logic [epwq_pkg::ROOT_BASE+FRAC_BITS-1:0] distance,
   input  logic [epwq_pkg::DLIM_W-1:0]          limit_depth,
   input  logic [epwq_pkg::PLIM_W-1:0]          limit_planar,
   output logic                                 done,
   output epwq_pkg::win_flags_type              flags
);
   import epwq_pkg::*;

   localparam int PD_W    = ROOT_BASE + FRAC_BITS;
   localparam int CNT_W   = $clog2(WINDOW + 1);
   localparam int IDX_W   = (WINDOW > 1) ? $clog2(WINDOW) : 1;
   localparam int DSUM_W  = DZ_W + CNT_W;
   localparam int PSUM_W  = PD_W + CNT_W;
   localparam int ZLIM_W  = DLIM_W + CNT_W;
   localparam int PLIMS_W = PLIM_W + CNT_W + FRAC_BITS;
   localparam int ENTRY_W = DZ_W + PD_W;
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(WINDOW);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(WINDOW - 1);

   typedef enum logic [1:0] {W_IDLE, W_READ, W_SUM, W_CMP} wstate_type;

   logic [ENTRY_W-1:0] mem [WINDOW];
   logic [ENTRY_W-1:0] rd_ff;

   wstate_type                state_ff;
   logic [CNT_W-1:0]          fill_ff;
   logic [IDX_W-1:0]          oldest_ff;
   logic signed [DSUM_W-1:0]  dsum_ff;
   logic [PSUM_W-1:0]         psum_ff;
   logic signed [DZ_W-1:0]    dz_ff;
   logic [PD_W-1:0]           dist_ff;
   logic [ZLIM_W-1:0]         zlim_ff;
   logic [PLIMS_W-1:0]        plim_ff;
   logic                      done_ff;
   win_flags_type             flags_ff;

   logic                      full;
   logic [IDX_W-1:0]          slot;
   logic [IDX_W-1:0]          oldest_in;
   logic [CNT_W-1:0]          fill_in;
   logic signed [DSUM_W-1:0]  old_dz;
   logic signed [DSUM_W-1:0]  new_dz;
   logic [PSUM_W-1:0]         old_pd;
   logic [PSUM_W-1:0]         new_pd;
   logic signed [DSUM_W-1:0]  dsum_in;
   logic [PSUM_W-1:0]         psum_in;
   logic signed [DSUM_W:0]    dsum_wide;
   logic signed [DSUM_W:0]    zpos;
   logic signed [DSUM_W:0]    zneg;
   logic                      eval_now;
   logic                      far_now;
   logic                      close_now;
   logic                      over_now;

   assign full      = (fill_ff == FULL_CNT);
   assign slot      = full ? oldest_ff : fill_ff[IDX_W-1:0];
   assign oldest_in = full ? ((oldest_ff == LAST_IDX) ? '0 : oldest_ff + IDX_W'(1)) : oldest_ff;
   assign fill_in   = full ? fill_ff : fill_ff + CNT_W'(1);

   assign old_dz  = full ? {{CNT_W{rd_ff[ENTRY_W-1]}}, rd_ff[ENTRY_W-1 -: DZ_W]} : '0;
   assign new_dz  = {{CNT_W{dz_ff[DZ_W-1]}}, dz_ff};
   assign old_pd  = full ? {{CNT_W{1'b0}}, rd_ff[PD_W-1:0]} : '0;
   assign new_pd  = {{CNT_W{1'b0}}, dist_ff};
   assign dsum_in = dsum_ff - old_dz + new_dz;
   assign psum_in = psum_ff - old_pd + new_pd;

   assign dsum_wide = {dsum_ff[DSUM_W-1], dsum_ff};
   assign zpos      = {{(DSUM_W + 1 - ZLIM_W){1'b0}}, zlim_ff};
   assign zneg      = -zpos;
   assign eval_now  = full;
   assign far_now   = eval_now && (dsum_wide > zpos);
   assign close_now = eval_now && !far_now && (dsum_wide < zneg);
   assign over_now  = eval_now && (psum_ff > {{(PSUM_W - PLIMS_W){1'b0}}, plim_ff});

   always_ff @(posedge clock) begin
      rd_ff <= mem[oldest_ff];
      if (state_ff == W_SUM) begin
         mem[slot] <= {dz_ff, dist_ff};
      end
   end

   always_ff @(posedge clock) begin
      done_ff <= 1'b0;
      case (state_ff)
         W_IDLE: begin
            if (start) begin
               dz_ff    <= dz;
               dist_ff  <= distance;
               state_ff <= W_READ;
            end
         end
         W_READ: begin
            zlim_ff  <= ZLIM_W'(32'(limit_depth) * WINDOW);
            plim_ff  <= PLIMS_W'((32'(limit_planar) * WINDOW) << FRAC_BITS);
            state_ff <= W_SUM;
         end
         W_SUM: begin
            dsum_ff   <= dsum_in;
            psum_ff   <= psum_in;
            fill_ff   <= fill_in;
            oldest_ff <= oldest_in;
            state_ff  <= W_CMP;
         end
         W_CMP: begin
            flags_ff.evaluated   <= eval_now;
            flags_ff.too_far     <= far_now;
            flags_ff.too_close   <= close_now;
            flags_ff.planar_over <= over_now;
            done_ff              <= 1'b1;
            if (far_now || close_now || over_now) begin
               dsum_ff   <= '0;
               psum_ff   <= '0;
               fill_ff   <= '0;
               oldest_ff <= '0;
            end
            state_ff <= W_IDLE;
         end
         default: begin
            state_ff <= W_IDLE;
         end
      endcase
      if (reset) begin
         state_ff  <= W_IDLE;
         done_ff   <= 1'b0;
         dsum_ff   <= '0;
         psum_ff   <= '0;
         fill_ff   <= '0;
         oldest_ff <= '0;
      end
   end

   assign done  = done_ff;
   assign flags = flags_ff;

endmodule

>>> rtl/core/eye_position_window_qualifier_core.sv
// Eye position window qualifier: offsets, planar distance root, window checks and flags.
//
//   channel  direction  handshake              payload
//   req      in         req_valid / req_ready  req_eye_x, req_eye_y, req_eye_depth
//   rsp      out        rsp_valid / rsp_ready  rsp_evaluated, rsp_too_* flags
//   csr      in         csr_write_enable       csr_index, csr_data
//
// The square root produces one root bit per cycle.
// Reset clears the window sums and counts and loads the register defaults.
// A waiting result does not block the next transfer; the next item holds
// before its window update until the result register is free.
module eye_position_window_qualifier_core #(
   parameter int WINDOW    = 20,
   parameter int FRAC_BITS = 4
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_ready,
   input  logic signed [epwq_pkg::X_W-1:0]       req_eye_x,
   input  logic signed [epwq_pkg::X_W-1:0]       req_eye_y,
   input  logic [epwq_pkg::DEPTH_W-1:0]          req_eye_depth,
   output logic                                  rsp_valid,
   input  logic                                  rsp_ready,
   output logic                                  rsp_evaluated,
   output logic                                  rsp_too_far,
   output logic                                  rsp_too_close,
   output logic                                  rsp_too_left,
   output logic                                  rsp_too_right,
   output logic                                  rsp_too_up,
   output logic                                  rsp_too_down,
   input  logic                                  csr_write_enable,
   input  logic [epwq_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [epwq_pkg::CSR_DATA_W-1:0]       csr_data
);
   import epwq_pkg::*;

   localparam int ROOT_W = ROOT_BASE + FRAC_BITS;
   localparam int RAD_W  = 2 * ROOT_W;

   typedef enum logic [2:0] {
      S_IDLE, S_SQX, S_SQY, S_ROOT_GO, S_ROOT, S_PUSH, S_WIN
   } state_type;

   state_type                  state_ff;
   logic [DLIM_W-1:0]          limit_depth_ff;
   logic [PLIM_W-1:0]          limit_planar_ff;
   logic signed [X_W-1:0]      ideal_x_ff;
   logic signed [X_W-1:0]      ideal_y_ff;
   logic [DEPTH_W-1:0]         ideal_depth_ff;

   logic signed [DX_W-1:0]     dx_ff;
   logic signed [DX_W-1:0]     dy_ff;
   logic signed [DZ_W-1:0]     dz_ff;
   logic [SQ_W-1:0]            sq_ff;

   logic                       rsp_valid_ff;
   logic                       evaluated_ff;
   logic                       far_ff;
   logic                       close_ff;
   logic                       left_ff;
   logic                       right_ff;
   logic                       up_ff;
   logic                       down_ff;

   logic signed [DX_W-1:0]     dx_in;
   logic signed [DX_W-1:0]     dy_in;
   logic signed [DZ_W-1:0]     dz_in;
   logic signed [DX_W-1:0]     d_sel;
   logic [DX_W-1:0]            d_abs;
   logic [MAG_W-1:0]           mag_sel;
   logic [2*MAG_W-1:0]         prod;
   logic [RAD_W-1:0]           radicand;
   logic                       root_start;
   logic                       root_done;
   logic [ROOT_W-1:0]          root;
   logic                       win_start;
   logic                       win_done;
   win_flags_type              win_flags;

   assign dx_in = {req_eye_x[X_W-1], req_eye_x} - {ideal_x_ff[X_W-1], ideal_x_ff};
   assign dy_in = {req_eye_y[X_W-1], req_eye_y} - {ideal_y_ff[X_W-1], ideal_y_ff};
   assign dz_in = {1'b0, req_eye_depth} - {1'b0, ideal_depth_ff};

   assign d_sel   = (state_ff == S_SQX) ? dx_ff : dy_ff;
   assign d_abs   = d_sel[DX_W-1] ? -d_sel : d_sel;
   assign mag_sel = d_abs[MAG_W-1:0];
   assign prod    = mag_sel * mag_sel;

   assign radicand   = RAD_W'(sq_ff) << (2 * FRAC_BITS);
   assign root_start = (state_ff == S_ROOT_GO);
   assign win_start  = (state_ff == S_PUSH) && (!rsp_valid_ff || rsp_ready);
   assign req_ready  = (state_ff == S_IDLE);

   epwq_sqrt #(
      .ROOT_W (ROOT_W)
   ) u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (root_start),
      .radicand (radicand),
      .done     (root_done),
      .root     (root)
   );

   epwq_window #(
      .WINDOW    (WINDOW),
      .FRAC_BITS (FRAC_BITS)
   ) u_window (
      .clock        (clock),
      .reset        (reset),
      .start        (win_start),
      .dz           (dz_ff),
      .distance     (root),
      .limit_depth  (limit_depth_ff),
      .limit_planar (limit_planar_ff),
      .done         (win_done),
      .flags        (win_flags)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         limit_depth_ff  <= LIMIT_DEPTH_RST;
         limit_planar_ff <= LIMIT_PLANAR_RST;
         ideal_x_ff      <= IDEAL_X_RST;
         ideal_y_ff      <= IDEAL_Y_RST;
         ideal_depth_ff  <= IDEAL_DEPTH_RST;
      end else if (csr_write_enable) begin
         case (csr_index)
            REG_LIMIT_DEPTH:  limit_depth_ff  <= csr_data[DLIM_W-1:0];
            REG_LIMIT_PLANAR: limit_planar_ff <= csr_data[PLIM_W-1:0];
            REG_IDEAL_X:      ideal_x_ff      <= csr_data[X_W-1:0];
            REG_IDEAL_Y:      ideal_y_ff      <= csr_data[X_W-1:0];
            REG_IDEAL_DEPTH:  ideal_depth_ff  <= csr_data[DEPTH_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               dx_ff    <= dx_in;
               dy_ff    <= dy_in;
               dz_ff    <= dz_in;
               state_ff <= S_SQX;
            end
         end
         S_SQX: begin
            sq_ff    <= SQ_W'(prod);
            state_ff <= S_SQY;
         end
         S_SQY: begin
            sq_ff    <= sq_ff + SQ_W'(prod);
            state_ff <= S_ROOT_GO;
         end
         S_ROOT_GO: begin
            state_ff <= S_ROOT;
         end
         S_ROOT: begin
            if (root_done) begin
               state_ff <= S_PUSH;
            end
         end
         S_PUSH: begin
            if (win_start) begin
               state_ff <= S_WIN;
            end
         end
         S_WIN: begin
            if (win_done) begin
               evaluated_ff <= win_flags.evaluated;
               far_ff       <= win_flags.too_far;
               close_ff     <= win_flags.too_close;
               left_ff      <= win_flags.planar_over && dx_ff[DX_W-1];
               right_ff     <= win_flags.planar_over && !dx_ff[DX_W-1];
               up_ff        <= win_flags.planar_over && dy_ff[DX_W-1];
               down_ff      <= win_flags.planar_over && !dy_ff[DX_W-1];
               rsp_valid_ff <= 1'b1;
               state_ff     <= S_IDLE;
            end
         end
         default: begin
            state_ff <= S_IDLE;
         end
      endcase
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_evaluated = evaluated_ff;
   assign rsp_too_far   = far_ff;
   assign rsp_too_close = close_ff;
   assign rsp_too_left  = left_ff;
   assign rsp_too_right = right_ff;
   assign rsp_too_up    = up_ff;
   assign rsp_too_down  = down_ff;

endmodule

>>> test/eye_position_window_qualifier_core_test.sv
// Self-checking testbench for the eye position window qualifier core.
`timescale 1ns / 1ps

module eye_position_window_qualifier_core_test;
   import epwq_pkg::*;

   localparam int WINDOW        = 20;
   localparam int FRAC_BITS     = 4;
   localparam int DIST_W        = ROOT_BASE + FRAC_BITS;
   localparam int LATENCY       = FRAC_BITS + 24;
   localparam int CYCLE_LIMIT   = 1_000_000;
   localparam int PHASES        = 10;
   localparam int PHASE_SAMPLES = 190;

   localparam logic signed [X_W-1:0] X_MIN = {1'b1, {(X_W-1){1'b0}}};
   localparam logic signed [X_W-1:0] X_MAX = {1'b0, {(X_W-1){1'b1}}};

   typedef struct packed {
      logic evaluated;
      logic too_far;
      logic too_close;
      logic too_left;
      logic too_right;
      logic too_up;
      logic too_down;
   } verdict_type;

   typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_type;

   class eye_window_checker;
      logic [DLIM_W-1:0]       limit_depth;
      logic [PLIM_W-1:0]       limit_planar;
      logic signed [X_W-1:0]   ideal_x;
      logic signed [X_W-1:0]   ideal_y;
      logic [DEPTH_W-1:0]      ideal_depth;
      logic signed [DZ_W-1:0]  depth_slots [WINDOW];
      logic [DIST_W-1:0]       planar_slots [WINDOW];
      longint                  depth_total;
      longint                  planar_total;
      int                      fill;
      int                      oldest;
      verdict_type             verdicts_due [$];
      int                      mismatches;
      int                      verdicts;
      int                      evaluated;
      int                      flagged;
      int                      samples;
      int                      writes;

      function new();
         limit_depth  = LIMIT_DEPTH_RST;
         limit_planar = LIMIT_PLANAR_RST;
         ideal_x      = IDEAL_X_RST;
         ideal_y      = IDEAL_Y_RST;
         ideal_depth  = IDEAL_DEPTH_RST;
         empty_window();
         mismatches = 0;
         verdicts   = 0;
         evaluated  = 0;
         flagged    = 0;
         samples    = 0;
         writes     = 0;
      endfunction

      function void empty_window();
         depth_total  = 0;
         planar_total = 0;
         fill         = 0;
         oldest       = 0;
      endfunction

      function void set_register(logic [CSR_IDX_W-1:0] index, logic [CSR_DATA_W-1:0] data);
         writes++;
         case (index)
            REG_LIMIT_DEPTH:  limit_depth  = data[DLIM_W-1:0];
            REG_LIMIT_PLANAR: limit_planar = data[PLIM_W-1:0];
            REG_IDEAL_X:      ideal_x      = signed'(data[X_W-1:0]);
            REG_IDEAL_Y:      ideal_y      = signed'(data[X_W-1:0]);
            REG_IDEAL_DEPTH:  ideal_depth  = data[DEPTH_W-1:0];
            default: ;
         endcase
      endfunction

      function longint floor_root(longint v);
         longint r;
         longint cand;
         r = 0;
         for (int b = DIST_W; b >= 0; b--) begin
            cand = r | (longint'(1) << b);
            if (cand * cand <= v) r = cand;
         end
         return r;
      endfunction

      function void note_sample(logic signed [X_W-1:0] x, logic signed [X_W-1:0] y,
                                logic [DEPTH_W-1:0] depth);
         int                dx;
         int                dy;
         int                dz;
         int                slot;
         longint            zlim;
         longint            plim;
         logic [DIST_W-1:0] distance;
         verdict_type       v;
         samples++;
         dx   = int'(x) - int'(ideal_x);
         dy   = int'(y) - int'(ideal_y);
         dz   = int'(depth) - int'(ideal_depth);
         distance = DIST_W'(floor_root((longint'(dx) * dx + longint'(dy) * dy)
                                       << (2 * FRAC_BITS)));
         v    = '0;
         if (fill >= WINDOW) begin
            slot = oldest;
            depth_total  -= depth_slots[slot];
            planar_total -= planar_slots[slot];
            oldest = (slot + 1) % WINDOW;
         end else begin
            slot = fill;
            fill++;
         end
         depth_slots[slot]  = DZ_W'(dz);
         planar_slots[slot] = distance;
         depth_total  += dz;
         planar_total += distance;
         if (fill == WINDOW) begin
            zlim = longint'(limit_depth) * WINDOW;
            plim = longint'(limit_planar) * WINDOW * (longint'(1) << FRAC_BITS);
            v.evaluated = 1'b1;
            if (depth_total > zlim) v.too_far = 1'b1;
            else if (depth_total < -zlim) v.too_close = 1'b1;
            if (planar_total > plim) begin
               v.too_left  = (dx < 0);
               v.too_right = (dx >= 0);
               v.too_up    = (dy < 0);
               v.too_down  = (dy >= 0);
            end
            if (v.too_far || v.too_close || v.too_left || v.too_right) empty_window();
         end
         verdicts_due.push_back(v);
      endfunction

      function void check_verdict(verdict_type got);
         verdict_type want;
         if (verdicts_due.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected verdict %b with none pending", got);
            return;
         end
         want = verdicts_due.pop_front();
         verdicts++;
         if (got.evaluated) evaluated++;
         if (got.too_far || got.too_close || got.too_left || got.too_right) flagged++;
         if (got !== want) begin
            mismatches++;
            if (mismatches <= 10)
               $display("verdict %0d mismatch, eval..down: expected %b, got %b",
                        verdicts, want, got);
         end
      endfunction

      function int pending();
         return verdicts_due.size();
      endfunction
   endclass

   logic                          clock;
   logic                          reset;
   logic                          req_valid;
   logic                          req_ready;
   logic signed [X_W-1:0]         req_eye_x;
   logic signed [X_W-1:0]         req_eye_y;
   logic [DEPTH_W-1:0]            req_eye_depth;
   logic                          rsp_valid;
   logic                          rsp_ready;
   logic                          rsp_evaluated;
   logic                          rsp_too_far;
   logic                          rsp_too_close;
   logic                          rsp_too_left;
   logic                          rsp_too_right;
   logic                          rsp_too_up;
   logic                          rsp_too_down;
   logic                          csr_write_enable;
   logic [CSR_IDX_W-1:0]          csr_index;
   logic [CSR_DATA_W-1:0]         csr_data;

   eye_window_checker window_model;
   int                send_gap_pct;
   int                stall_pct;
   int                depth_bias;
   int                cycles;

   eye_position_window_qualifier_core #(
      .WINDOW    (WINDOW),
      .FRAC_BITS (FRAC_BITS)
   ) u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_eye_x        (req_eye_x),
      .req_eye_y        (req_eye_y),
      .req_eye_depth    (req_eye_depth),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_evaluated    (rsp_evaluated),
      .rsp_too_far      (rsp_too_far),
      .rsp_too_close    (rsp_too_close),
      .rsp_too_left     (rsp_too_left),
      .rsp_too_right    (rsp_too_right),
      .rsp_too_up       (rsp_too_up),
      .rsp_too_down     (rsp_too_down),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && req_ready)
            window_model.note_sample(req_eye_x, req_eye_y, req_eye_depth);
         if (rsp_valid && rsp_ready)
            window_model.check_verdict(verdict_type'({rsp_evaluated, rsp_too_far,
                                                      rsp_too_close, rsp_too_left,
                                                      rsp_too_right, rsp_too_up,
                                                      rsp_too_down}));
      end
      rsp_ready <= (int'($urandom_range(0, 99)) >= stall_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d verdicts pending", cycles,
                  window_model.pending());
         $display("eye_position_window_qualifier_core verification failed");
         $finish;
      end
   end

   function automatic int clamp(int v, int lo, int hi);
      return (v < lo) ? lo : (v > hi) ? hi : v;
   endfunction

   task automatic set_idle(input idle_mode_type mode);
      case (mode)
         IDLE_NONE:     begin send_gap_pct = 0;  stall_pct = 0;  end
         IDLE_SENDER:   begin send_gap_pct = 86; stall_pct = 0;  end
         IDLE_RECEIVER: begin send_gap_pct = 0;  stall_pct = 86; end
         IDLE_BOTH:     begin send_gap_pct = 26; stall_pct = 26; end
      endcase
   endtask

   task automatic send_sample(input logic signed [X_W-1:0] x, input logic signed [X_W-1:0] y,
                              input logic [DEPTH_W-1:0] d);
      req_valid     <= 1'b1;
      req_eye_x     <= x;
      req_eye_y     <= y;
      req_eye_depth <= d;
      do @(posedge clock); while (!req_ready);
      while (int'($urandom_range(0, 99)) < send_gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   // drop valid and hold until every verdict has come back
   task automatic settle();
      req_valid <= 1'b0;
      @(posedge clock);
      while (window_model.pending() != 0) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_IDX_W-1:0] index, input int value);
      csr_write_enable <= 1'b1;
      csr_index        <= index;
      csr_data         <= CSR_DATA_W'(value);
      window_model.set_register(index, CSR_DATA_W'(value));
      @(posedge clock);
   endtask

   task automatic program_phase(input int p);
      int ld;
      int lp;
      int ix;
      int iy;
      int idp;
      case (p)
         1: begin ld = 0; lp = 0; ix = 0; iy = 0; idp = 2048; end
         2: begin ld = 13'h1FFF; lp = 8191; ix = 4095; iy = -4096; idp = 13'h1FFF; end
         3: begin ld = 1; lp = 1; ix = -4096; iy = 4095; idp = 0; end
         default: begin
            ld  = int'($urandom_range(0, 400)) | (int'($urandom_range(0, 1)) << 12);
            lp  = ($urandom_range(0, 3) == 0) ? int'($urandom_range(0, 8191))
                                              : int'($urandom_range(0, 400));
            ix  = int'($urandom_range(0, 1000)) - 500;
            iy  = int'($urandom_range(0, 1000)) - 500;
            idp = int'($urandom_range(200, 3000)) | (int'($urandom_range(0, 1)) << 12);
         end
      endcase
      write_register(REG_LIMIT_DEPTH, ld);
      write_register(REG_LIMIT_PLANAR, lp);
      write_register(REG_IDEAL_X, ix);
      write_register(REG_IDEAL_Y, iy);
      write_register(REG_IDEAL_DEPTH, idp);
      write_register(REG_IDEAL_DEPTH + 3'(1 + $urandom_range(0, 2)), int'($urandom));
      csr_write_enable <= 1'b0;
   endtask

   // mostly samples scattered around the ideal point so window means land near the limits
   task automatic make_sample(output logic signed [X_W-1:0] x, output logic signed [X_W-1:0] y,
                              output logic [DEPTH_W-1:0] d);
      int pick;
      int spread;
      int dspan;
      pick = int'($urandom_range(0, 99));
      if (pick < 72) begin
         spread = int'(window_model.limit_planar) * 13 / 10 + int'($urandom_range(0, 3));
         dspan  = int'(window_model.limit_depth);
         x = X_W'(clamp(int'(window_model.ideal_x) + int'($urandom_range(0, 2 * spread))
                        - spread, int'(X_MIN), int'(X_MAX)));
         y = X_W'(clamp(int'(window_model.ideal_y) + int'($urandom_range(0, 2 * spread))
                        - spread, int'(X_MIN), int'(X_MAX)));
         d = DEPTH_W'(clamp(int'(window_model.ideal_depth) + depth_bias
                            + int'($urandom_range(0, 2 * dspan)) - dspan,
                            0, (1 << DEPTH_W) - 1));
      end else if (pick < 86) begin
         x = X_W'($urandom);
         y = X_W'($urandom);
         d = DEPTH_W'($urandom);
      end else begin
         x = $urandom_range(0, 1) ? X_MAX : X_MIN;
         y = $urandom_range(0, 1) ? X_MAX : X_MIN;
         d = $urandom_range(0, 1) ? '1 : '0;
      end
   endtask

   initial begin
      logic signed [X_W-1:0] sx;
      logic signed [X_W-1:0] sy;
      logic [DEPTH_W-1:0]    sd;
      int                    span;
      window_model     = new();
      depth_bias       = 0;
      reset            <= 1'b1;
      req_valid        <= 1'b0;
      req_eye_x        <= '0;
      req_eye_y        <= '0;
      req_eye_depth    <= '0;
      csr_write_enable <= 1'b0;
      csr_index        <= '0;
      csr_data         <= '0;
      set_idle(IDLE_NONE);
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // fill a window with corner samples, end it on the ideal point, then send five more near it
      for (int i = 0; i < 25; i++) begin
         if (i < 19) begin
            sx = i[0] ? X_MAX : X_MIN;
            sy = i[1] ? X_MAX : X_MIN;
            sd = (i % 3 == 0) ? '0 : '1;
         end else if (i == 19) begin
            sx = IDEAL_X_RST;
            sy = IDEAL_Y_RST;
            sd = IDEAL_DEPTH_RST;
         end else begin
            sx = X_W'(int'(IDEAL_X_RST) + i - 22);
            sy = X_W'(int'(IDEAL_Y_RST) + 22 - i);
            sd = DEPTH_W'(int'(IDEAL_DEPTH_RST) + i - 22);
         end
         send_sample(sx, sy, sd);
      end

      for (int p = 1; p <= PHASES; p++) begin
         settle();
         program_phase(p);
         set_idle(idle_mode_type'(p % 4));
         for (int n = 0; n < PHASE_SAMPLES; n++) begin
            if (n == PHASE_SAMPLES / 2) settle();
            if (n % 10 == 0) begin
               span = int'(window_model.limit_depth) * 5 / 4 + 2;
               depth_bias = int'($urandom_range(0, 2 * span)) - span;
            end
            make_sample(sx, sy, sd);
            send_sample(sx, sy, sd);
         end
      end

      settle();
      repeat (2 * LATENCY) @(posedge clock);
      $display("sent %0d eye samples over %0d register settings (%0d register writes)",
               window_model.samples, PHASES + 1, window_model.writes);
      $display("checked %0d verdicts: %0d evaluated, %0d flagged windows, %0d mismatches",
               window_model.verdicts, window_model.evaluated, window_model.flagged,
               window_model.mismatches);
      if (window_model.mismatches == 0 && window_model.pending() == 0)
         $display("eye_position_window_qualifier_core verification clean");
      else
         $display("eye_position_window_qualifier_core verification failed");
      $finish;
   end

endmodule

>>> files.f
rtl/core/epwq_pkg.sv
rtl/core/epwq_sqrt.sv
rtl/core/epwq_window.sv
rtl/core/eye_position_window_qualifier_core.sv
test/eye_position_window_qualifier_core_test.sv
